// ===== rtl/rtp_pkg.sv =====
// Shared types, codes and constants of the RTTTL ringtone parser.
// Used by the front parser, the note queue, the duration unit and the top level.
package rtp_pkg;

    localparam int unsigned MAX_DOTS_DEFAULT    = 3;
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [19:0] MS_MAX = 20'hFFFFF;

    typedef enum logic [1:0] {
        KIND_NOTE = 2'd0,
        KIND_REST = 2'd1,
        KIND_END  = 2'd2
    } note_kind_t;

    // One parsed note as it travels from the parser to the duration unit.
    typedef struct packed {
        note_kind_t         kind;
        logic [2:0]         letter;
        logic               sharp;
        logic signed [4:0]  octave;
        logic [9:0]         bpm;
        logic [9:0]         dur;
        logic [1:0]         dots;
        logic               song_end;
    } note_desc_t;

    // Whole-note length in ms times 3^k for k dots.
    function automatic logic [22:0] dot_numerator(input logic [1:0] dots);
        logic [22:0] num;
        unique case (dots)
            2'd0:    num = 23'd240000;
            2'd1:    num = 23'd720000;
            2'd2:    num = 23'd2160000;
            default: num = 23'd6480000;
        endcase
        return num;
    endfunction

endpackage

// ===== rtl/rtp_queue.sv =====
// Short FIFO of parsed note descriptors between the parser and the duration unit.
// Depends on rtp_pkg for the descriptor type.
module rtp_queue #(
    parameter int unsigned DEPTH = rtp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rtp_pkg::note_desc_t push_data,
    output logic                full,
    input  logic                pop,
    output rtp_pkg::note_desc_t pop_data,
    output logic                empty
);

    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    rtp_pkg::note_desc_t entries_reg [DEPTH];
    logic [IDX_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/rtp_front.sv =====
// Byte parser of the RTTTL ringtone parser: name, defaults and note syntax.
// Depends on rtp_pkg; pushes a descriptor into the queue per finished note and on the last byte.
module rtp_front #(
    parameter int unsigned MAX_DOTS = rtp_pkg::MAX_DOTS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          text_byte,
    input  logic                last_byte,
    input  logic                q_full,
    output logic                push,
    output rtp_pkg::note_desc_t desc
);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_FLAT  = 8'h62;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [3:0] CODE_REST = 4'd7;
    localparam logic [3:0] CODE_NONE = 4'd8;

    localparam int unsigned FL_SHARP = 0;
    localparam int unsigned FL_REST  = 1;
    localparam int unsigned FL_LOW   = 2;

    typedef enum logic [2:0] {
        PH_NAME  = 3'b001,
        PH_META  = 3'b010,
        PH_NOTES = 3'b100
    } phase_t;

    typedef enum logic [7:0] {
        SP_IDLE   = 8'b0000_0001,
        SP_DUR    = 8'b0000_0010,
        SP_LETTER = 8'b0000_0100,
        SP_SHARP  = 8'b0000_1000,
        SP_FLAT   = 8'b0001_0000,
        SP_DOTS   = 8'b0010_0000,
        SP_OCT    = 8'b0100_0000,
        SP_TAIL   = 8'b1000_0000
    } subphase_t;

    typedef enum logic [2:0] {
        KEY_DUR = 3'b001,
        KEY_OCT = 3'b010,
        KEY_BPM = 3'b100
    } key_t;

    phase_t     phase_reg, phase_next;
    subphase_t  sp_reg, sp_next;
    key_t       key_reg, key_next;
    logic [9:0] ddur_reg, ddur_next;
    logic [3:0] doct_reg, doct_next;
    logic [9:0] bpm_reg, bpm_next;
    logic [9:0] pdur_reg, pdur_next;
    logic [1:0] pdots_reg, pdots_next;
    logic [2:0] pletter_reg, pletter_next;
    logic [2:0] pflags_reg, pflags_next;
    logic [3:0] poct_reg, poct_next;

    logic       accept;
    logic       got;
    logic       is_digit;
    logic [3:0] dval;
    logic [3:0] code;
    logic       open_note;

    // Decimal accumulate, saturating at the largest value of the result width.
    function automatic logic [9:0] acc_sat10(input logic [9:0] v, input logic [3:0] d);
        logic [13:0] r;
        r = {v, 3'b000} + {3'b000, v, 1'b0} + {10'd0, d};
        return (r > 14'd1023) ? 10'd1023 : r[9:0];
    endfunction

    function automatic logic [3:0] acc_sat4(input logic [3:0] v, input logic [3:0] d);
        logic [7:0] r;
        r = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {4'd0, d};
        return (r > 8'd15) ? 4'd15 : r[3:0];
    endfunction

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
    assign dval     = text_byte[3:0];

    always_comb
    begin
        if (text_byte >= 8'h41 && text_byte <= 8'h47)
        begin
            code = 4'(text_byte - 8'h41);
        end
        else if (text_byte >= 8'h61 && text_byte <= 8'h67)
        begin
            code = 4'(text_byte - 8'h61);
        end
        else if (text_byte == 8'h70 || text_byte == 8'h50)
        begin
            code = CODE_REST;
        end
        else
        begin
            code = CODE_NONE;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        sp_next      = sp_reg;
        key_next     = key_reg;
        ddur_next    = ddur_reg;
        doct_next    = doct_reg;
        bpm_next     = bpm_reg;
        pdur_next    = pdur_reg;
        pdots_next   = pdots_reg;
        pletter_next = pletter_reg;
        pflags_next  = pflags_reg;
        poct_next    = poct_reg;
        got          = 1'b0;

        unique case (phase_reg)
            PH_NAME:
            begin
                if (text_byte == CH_COLON)
                begin
                    phase_next = PH_META;
                end
            end
            PH_META:
            begin
                priority if (text_byte == CH_COLON)
                begin
                    phase_next = PH_NOTES;
                end
                else if (text_byte == 8'h64 || text_byte == 8'h44)
                begin
                    key_next  = KEY_DUR;
                    ddur_next = '0;
                end
                else if (text_byte == 8'h6F || text_byte == 8'h4F)
                begin
                    key_next  = KEY_OCT;
                    doct_next = '0;
                end
                else if (text_byte == 8'h62 || text_byte == 8'h42)
                begin
                    key_next = KEY_BPM;
                    bpm_next = '0;
                end
                else if (is_digit)
                begin
                    if (key_reg == KEY_OCT)
                    begin
                        doct_next = acc_sat4(doct_reg, dval);
                    end
                    else if (key_reg == KEY_BPM)
                    begin
                        bpm_next = acc_sat10(bpm_reg, dval);
                    end
                    else
                    begin
                        ddur_next = acc_sat10(ddur_reg, dval);
                    end
                end
                else
                begin
                    key_next = key_reg;
                end
            end
            PH_NOTES:
            begin
                if (sp_reg == SP_IDLE || sp_reg == SP_DUR)
                begin
                    if (is_digit)
                    begin
                        pdur_next = (sp_reg == SP_IDLE) ? {6'd0, dval}
                                                         : acc_sat10(pdur_reg, dval);
                        sp_next   = SP_DUR;
                    end
                    else if (code != CODE_NONE)
                    begin
                        // A note letter or a rest opens a note.
                        if (sp_reg == SP_IDLE)
                        begin
                            pdur_next = ddur_reg;
                        end
                        pletter_next = (code < CODE_REST) ? code[2:0] : 3'd0;
                        pflags_next  = (code == CODE_REST) ? 3'b010 : 3'b000;
                        poct_next    = doct_reg;
                        pdots_next   = '0;
                        sp_next      = SP_LETTER;
                    end
                    else
                    begin
                        sp_next = SP_IDLE;
                    end
                end
                else
                begin
                    priority if (text_byte == CH_HASH && sp_reg == SP_LETTER)
                    begin
                        if (!pflags_reg[FL_REST])
                        begin
                            pflags_next[FL_SHARP] = 1'b1;
                        end
                        sp_next = SP_SHARP;
                    end
                    else if (text_byte == CH_FLAT && (sp_reg == SP_LETTER || sp_reg == SP_SHARP))
                    begin
                        // A flat is the sharp of the letter below; A wraps to G an octave down.
                        if (!pflags_reg[FL_REST])
                        begin
                            if (pletter_reg == 3'd0)
                            begin
                                pletter_next        = 3'd6;
                                pflags_next[FL_LOW] = 1'b1;
                            end
                            else
                            begin
                                pletter_next = pletter_reg - 3'd1;
                            end
                            pflags_next[FL_SHARP] = 1'b1;
                        end
                        sp_next = SP_FLAT;
                    end
                    else if (text_byte == CH_DOT && sp_reg != SP_TAIL)
                    begin
                        if (32'(pdots_reg) < MAX_DOTS)
                        begin
                            pdots_next = pdots_reg + 2'd1;
                        end
                        sp_next = (sp_reg == SP_OCT) ? SP_OCT : SP_DOTS;
                    end
                    else if (is_digit && sp_reg != SP_OCT && sp_reg != SP_TAIL)
                    begin
                        poct_next = dval;
                        sp_next   = SP_OCT;
                    end
                    else if (text_byte == CH_SPACE)
                    begin
                        sp_next = SP_TAIL;
                    end
                    else
                    begin
                        got     = 1'b1;
                        sp_next = SP_IDLE;
                    end
                end
            end
            default:
            begin
                phase_next = PH_NAME;
            end
        endcase

        open_note = (phase_next == PH_NOTES) && (sp_next != SP_IDLE) && (sp_next != SP_DUR);

        // The note fields do not change on a delimiter, so the updated values
        // serve both a delimited note and a note left open at the last byte.
        desc.song_end = last_byte;
        if (got || open_note)
        begin
            desc.kind   = pflags_next[FL_REST] ? rtp_pkg::KIND_REST : rtp_pkg::KIND_NOTE;
            desc.letter = pflags_next[FL_REST] ? 3'd0 : pletter_next;
            desc.sharp  = !pflags_next[FL_REST] && pflags_next[FL_SHARP];
            desc.octave = pflags_next[FL_REST] ? 5'sd0
                        : signed'({1'b0, poct_next} - {4'd0, pflags_next[FL_LOW]});
            desc.bpm    = bpm_next;
            desc.dur    = pdur_next;
            desc.dots   = pdots_next;
        end
        else
        begin
            desc.kind   = rtp_pkg::KIND_END;
            desc.letter = '0;
            desc.sharp  = 1'b0;
            desc.octave = '0;
            desc.bpm    = '0;
            desc.dur    = '0;
            desc.dots   = '0;
        end

        push = accept && (got || last_byte);

        if (last_byte)
        begin
            phase_next   = PH_NAME;
            sp_next      = SP_IDLE;
            key_next     = KEY_DUR;
            ddur_next    = '0;
            doct_next    = '0;
            bpm_next     = '0;
            pdur_next    = '0;
            pdots_next   = '0;
            pletter_next = '0;
            pflags_next  = '0;
            poct_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_NAME;
            sp_reg      <= SP_IDLE;
            key_reg     <= KEY_DUR;
            ddur_reg    <= '0;
            doct_reg    <= '0;
            bpm_reg     <= '0;
            pdur_reg    <= '0;
            pdots_reg   <= '0;
            pletter_reg <= '0;
            pflags_reg  <= '0;
            poct_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            sp_reg      <= sp_next;
            key_reg     <= key_next;
            ddur_reg    <= ddur_next;
            doct_reg    <= doct_next;
            bpm_reg     <= bpm_next;
            pdur_reg    <= pdur_next;
            pdots_reg   <= pdots_next;
            pletter_reg <= pletter_next;
            pflags_reg  <= pflags_next;
            poct_reg    <= poct_next;
        end
    end

endmodule

// ===== rtl/rtp_duration.sv =====
// Duration unit: multiplies tempo by note value, then divides one bit per cycle.
// Depends on rtp_pkg; pops descriptors from the queue and drives the output register.
module rtp_duration (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_empty,
    output logic                     pop,
    input  rtp_pkg::note_desc_t      item,
    output logic                     out_valid,
    input  logic                     out_ready,
    output rtp_pkg::note_kind_t      note_kind,
    output logic [2:0]               note_letter,
    output logic                     sharp,
    output logic signed [4:0]        note_octave,
    output logic [19:0]              duration_ms,
    output logic                     song_end
);

    localparam int unsigned DIV_W     = 25;
    localparam int unsigned DEN_W     = 24;
    localparam int unsigned CNT_W     = $clog2(DIV_W + 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_PREP = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]    cnt_reg;
    rtp_pkg::note_desc_t item_reg;
    logic [19:0]         prod_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [DEN_W-1:0]    rem_reg;
    logic [DIV_W-1:0]    quo_reg;

    logic [22:0]         den_sh;
    logic [DIV_W-1:0]    shifted;
    logic                fits;
    logic [DIV_W-1:0]    diff;
    logic                load_out;
    logic [19:0]         ms;

    assign pop       = (state_reg == ST_IDLE) && !q_empty;
    assign out_valid = out_valid_reg;
    assign load_out  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // Round half up: (2*num + den) / (2*den); a zero divisor gives all ones.
    assign den_sh  = {3'd0, prod_reg} << item_reg.dots;
    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign fits    = shifted >= {1'b0, den_reg};
    assign diff    = shifted - {1'b0, den_reg};

    always_comb
    begin
        if (item_reg.kind == rtp_pkg::KIND_END)
        begin
            ms = '0;
        end
        else if (quo_reg > DIV_W'(rtp_pkg::MS_MAX))
        begin
            ms = rtp_pkg::MS_MAX;
        end
        else
        begin
            ms = quo_reg[19:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_PREP)
            begin
                cnt_reg <= CNT_W'(DIV_W);
            end
            else if (state_reg == ST_DIV)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= item;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= item_reg.bpm * item_reg.dur;
        end
        if (state_reg == ST_PREP)
        begin
            den_reg <= {den_sh, 1'b0};
            rem_reg <= '0;
            quo_reg <= {1'b0, rtp_pkg::dot_numerator(item_reg.dots), 1'b0} + {2'd0, den_sh};
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
        if (load_out)
        begin
            note_kind   <= item_reg.kind;
            note_letter <= item_reg.letter;
            sharp       <= item_reg.sharp;
            note_octave <= item_reg.octave;
            duration_ms <= ms;
            song_end    <= item_reg.song_end;
        end
    end

endmodule

// ===== rtl/rtttl_ringtone_parser.sv =====
// Top level of the RTTTL ringtone parser: parser, note queue and duration unit.
// Depends on rtp_pkg, rtp_front, rtp_queue and rtp_duration.
//
// The input channel takes one character of ringtone text per transaction,
// with last_byte marking the final character. The parser skips the song
// name, reads the d=, o= and b= defaults and then parses notes. A note is
// produced when its delimiter arrives; the last byte always produces one
// output transaction with song_end set, the note it closes or leaves open or
// an end marker (note_kind 2), and then the parser returns to its reset state.
// The parser takes one byte per cycle as long as the note queue has room.
// The duration unit handles one note at a time: a pop, the tempo times note
// value product, a setup step, a one-bit-per-cycle restoring divider and the
// load of the output register; it pops no new note until that load is done.
// The queue absorbs bursts of short notes. When the receiver stalls, the
// result waits in the output register, the unit holds its next result, the
// queue fills and in_ready falls.
// Reset (rst_n, asynchronous, active low) empties the queue and the output.
module rtttl_ringtone_parser #(
    parameter int unsigned MAX_DOTS    = rtp_pkg::MAX_DOTS_DEFAULT,
    parameter int unsigned QUEUE_DEPTH = rtp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          text_byte,
    input  logic                last_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output rtp_pkg::note_kind_t note_kind,
    output logic [2:0]          note_letter,
    output logic                sharp,
    output logic signed [4:0]   note_octave,
    output logic [19:0]         duration_ms,
    output logic                song_end
);

    logic                q_full;
    logic                q_empty;
    logic                push;
    logic                pop;
    rtp_pkg::note_desc_t push_desc;
    rtp_pkg::note_desc_t pop_desc;

    // Front: classifies each byte and builds note descriptors.
    rtp_front #(
        .MAX_DOTS (MAX_DOTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .text_byte (text_byte),
        .last_byte (last_byte),
        .q_full    (q_full),
        .push      (push),
        .desc      (push_desc)
    );

    // Queue: decouples byte parsing from the multi-cycle duration math.
    rtp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_desc),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_desc),
        .empty     (q_empty)
    );

    // Back: computes the note length and presents the result.
    rtp_duration u_duration (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .pop         (pop),
        .item        (pop_desc),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .note_kind   (note_kind),
        .note_letter (note_letter),
        .sharp       (sharp),
        .note_octave (note_octave),
        .duration_ms (duration_ms),
        .song_end    (song_end)
    );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the RTTTL ringtone parser: a short table of directed text, then
// random ringtones; notes checked field by field against typed rows or a local model.
// Depends on rtp_pkg (note kinds, dot limit, saturation value) and rtttl_ringtone_parser.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 8;
    localparam int IDLE_PCT      = 8;      // chance per cycle that a side idles
    localparam int RANDOM_BYTES  = 600;
    localparam int QUIET_LIMIT   = 2000;   // cycles without any transaction
    localparam int TAIL_CYCLES   = 64;     // cycles left to run after the output drains
    localparam int DOT_LIMIT     = rtp_pkg::MAX_DOTS_DEFAULT;
    localparam int WHOLE_NOTE_MS = 240000;
    localparam int DIR_ROWS      = 25;

    // Characters with a meaning of their own in the ringtone text.
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_NINE  = "9";
    localparam logic [7:0] CH_COLON = ":";
    localparam logic [7:0] CH_HASH  = "#";
    localparam logic [7:0] CH_FLAT  = "b";
    localparam logic [7:0] CH_DOT   = ".";
    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_COMMA = ",";

    // Letter codes: 0 is A and 6 is G, then a rest, then a byte that starts nothing.
    localparam int LETTER_A  = 0;
    localparam int LETTER_G  = 6;
    localparam int CODE_REST = 7;
    localparam int CODE_NONE = 8;

    typedef enum logic [1:0] {SONG_TITLE, SONG_DEFAULTS, SONG_NOTES} song_phase_t;
    typedef enum logic [1:0] {DEF_LEN, DEF_OCT, DEF_BPM} meta_key_t;
    // The order matters: several rules apply to every step up to a given one.
    typedef enum logic [2:0] {
        NS_AWAIT, NS_DIGITS, NS_LETTER, NS_SHARPED,
        NS_FLATTED, NS_DOTTED, NS_OCTAVE, NS_SPACED
    } note_step_t;

    // One result transaction, laid out in the order of the output ports.
    typedef struct packed {
        rtp_pkg::note_kind_t kind;
        logic [2:0]          letter;
        logic                sharp;
        logic signed [4:0]   octave;
        logic [19:0]         ms;
        logic                song_end;
    } ringtone_note_t;

    // One row of the directed text; typed rows carry their result written out by hand.
    typedef struct packed {
        logic [7:0]     ch;
        logic           fin;
        logic           typed;
        ringtone_note_t want;
    } text_row_t;

    localparam ringtone_note_t NO_NOTE = '0;
    localparam ringtone_note_t END_MARK = '{kind: rtp_pkg::KIND_END, letter: 3'd0,
                                            sharp: 1'b0, octave: 5'sd0, ms: 20'd0,
                                            song_end: 1'b1};
    // A flat at default octave 0 with no duration: G sharp one octave below, saturated.
    localparam ringtone_note_t A_FLAT_LOW = '{kind: rtp_pkg::KIND_NOTE, letter: 3'd6,
                                              sharp: 1'b1, octave: -5'sd1,
                                              ms: rtp_pkg::MS_MAX, song_end: 1'b0};
    // A 32nd rest at 1023 bpm: 240000 / 32736 rounds to 7 ms.
    localparam ringtone_note_t SHORT_REST = '{kind: rtp_pkg::KIND_REST, letter: 3'd0,
                                              sharp: 1'b0, octave: 5'sd0, ms: 20'd7,
                                              song_end: 1'b0};

    // The directed text. It opens with a last byte straight out of reset, then a song
    // with an empty name, a duration key cleared to zero and a tempo that saturates.
    // The notes cover a flat on A, a 32nd rest whose sharp is dropped, a byte that
    // starts no note, more dots than count, and a note closed by the last byte.
    text_row_t dir_rows [DIR_ROWS] = '{
        '{8'h00, 1'b1, 1'b1, END_MARK},
        '{":",   1'b0, 1'b0, NO_NOTE},
        '{"d",   1'b0, 1'b0, NO_NOTE},
        '{"B",   1'b0, 1'b0, NO_NOTE},
        '{"9",   1'b0, 1'b0, NO_NOTE},
        '{"9",   1'b0, 1'b0, NO_NOTE},
        '{"9",   1'b0, 1'b0, NO_NOTE},
        '{"9",   1'b0, 1'b0, NO_NOTE},
        '{":",   1'b0, 1'b0, NO_NOTE},
        '{"a",   1'b0, 1'b0, NO_NOTE},
        '{"b",   1'b0, 1'b0, NO_NOTE},
        '{",",   1'b0, 1'b1, A_FLAT_LOW},
        '{"3",   1'b0, 1'b0, NO_NOTE},
        '{"2",   1'b0, 1'b0, NO_NOTE},
        '{"p",   1'b0, 1'b0, NO_NOTE},
        '{"#",   1'b0, 1'b0, NO_NOTE},
        '{",",   1'b0, 1'b1, SHORT_REST},
        '{"z",   1'b0, 1'b0, NO_NOTE},
        '{"G",   1'b0, 1'b0, NO_NOTE},
        '{".",   1'b0, 1'b0, NO_NOTE},
        '{".",   1'b0, 1'b0, NO_NOTE},
        '{".",   1'b0, 1'b0, NO_NOTE},
        '{".",   1'b0, 1'b0, NO_NOTE},
        '{"5",   1'b0, 1'b0, NO_NOTE},
        '{8'hFF, 1'b1, 1'b0, NO_NOTE}
    };

    // Every input of the block starts at a known value.
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] text_byte = 8'h00;
    logic       last_byte = 1'b0;
    logic       out_ready = 1'b0;

    logic                in_ready;
    logic                out_valid;
    rtp_pkg::note_kind_t note_kind;
    logic [2:0]          note_letter;
    logic                sharp;
    logic signed [4:0]   note_octave;
    logic [19:0]         duration_ms;
    logic                song_end;
    ringtone_note_t      seen_note;

    // Notes predicted but not yet seen on the output, oldest first.
    ringtone_note_t note_q [$];
    logic [7:0]     song_chars [$];

    bit steady = 1'b0;   // when set, neither side idles
    int errors = 0;
    int text_sent = 0;
    int notes_seen = 0;
    int rests_seen = 0;
    int marks_seen = 0;
    int quiet = 0;

    // State of the parser model.
    song_phase_t phase;
    note_step_t  step;
    meta_key_t   key;
    logic [9:0]  def_len;
    logic [9:0]  bpm;
    logic [9:0]  cur_len;
    logic [3:0]  def_oct;
    logic [3:0]  cur_oct;
    logic [1:0]  cur_dots;
    logic [2:0]  cur_letter;
    logic        cur_sharp;
    logic        cur_rest;
    logic        cur_low;

    rtttl_ringtone_parser dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_byte   (text_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .note_kind   (note_kind),
        .note_letter (note_letter),
        .sharp       (sharp),
        .note_octave (note_octave),
        .duration_ms (duration_ms),
        .song_end    (song_end)
    );

    assign seen_note = {note_kind, note_letter, sharp, note_octave, duration_ms, song_end};

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------

    function automatic void clear_parser();
        phase      = SONG_TITLE;
        step       = NS_AWAIT;
        key        = DEF_LEN;
        def_len    = '0;
        def_oct    = '0;
        bpm        = '0;
        cur_len    = '0;
        cur_oct    = '0;
        cur_dots   = '0;
        cur_letter = '0;
        cur_sharp  = 1'b0;
        cur_rest   = 1'b0;
        cur_low    = 1'b0;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // Appends a decimal digit and clamps at the limit, the way the state registers do.
    function automatic logic [9:0] add_digit(input logic [9:0] v, input logic [7:0] c,
                                             input int lim);
        int r;
        r = int'(v) * 10 + int'(c) - int'(CH_ZERO);
        return (r > lim) ? 10'(lim) : 10'(r);
    endfunction

    function automatic int letter_code(input logic [7:0] c);
        if (c >= "A" && c <= "G") return int'(c) - int'("A");
        if (c >= "a" && c <= "g") return int'(c) - int'("a");
        if (c == "p" || c == "P") return CODE_REST;
        return CODE_NONE;
    endfunction

    function automatic void start_note(input int code);
        cur_letter = (code < CODE_REST) ? 3'(code) : 3'(LETTER_A);
        cur_rest   = (code == CODE_REST);
        cur_sharp  = 1'b0;
        cur_low    = 1'b0;
        cur_oct    = def_oct;
        cur_dots   = '0;
        step       = NS_LETTER;
    endfunction

    // ms = round(240000 * 3^k / (bpm * d * 2^k)), halves up, in exact integers.
    function automatic logic [19:0] note_length_ms();
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        num = WHOLE_NOTE_MS;
        den = 64'(bpm) * 64'(cur_len);
        for (int i = 0; i < int'(cur_dots); i++)
        begin
            num = num * 3;
            den = den * 2;
        end
        if (den == 0) return rtp_pkg::MS_MAX;
        q = (2 * num + den) / (2 * den);
        return (q > 64'(rtp_pkg::MS_MAX)) ? rtp_pkg::MS_MAX : 20'(q);
    endfunction

    function automatic ringtone_note_t open_note();
        ringtone_note_t r;
        logic [4:0] oct;
        oct        = {1'b0, cur_oct} - {4'd0, cur_low};
        r.kind     = cur_rest ? rtp_pkg::KIND_REST : rtp_pkg::KIND_NOTE;
        r.letter   = cur_rest ? 3'd0 : cur_letter;
        r.sharp    = !cur_rest && cur_sharp;
        r.octave   = cur_rest ? 5'sd0 : oct;
        r.ms       = note_length_ms();
        r.song_end = 1'b0;
        return r;
    endfunction

    // One character in the notes section; returns 1 when it ends a note.
    function automatic bit note_char(input logic [7:0] c, output ringtone_note_t r);
        int code;
        code = letter_code(c);
        r = NO_NOTE;
        if (step == NS_AWAIT)
        begin
            if (is_digit(c))
            begin
                cur_len = 10'(c - CH_ZERO);
                step = NS_DIGITS;
            end
            else if (code != CODE_NONE)
            begin
                cur_len = def_len;
                start_note(code);
            end
            return 1'b0;
        end
        if (step == NS_DIGITS)
        begin
            // A byte that starts no note drops the digits read so far.
            if (is_digit(c)) cur_len = add_digit(cur_len, c, 1023);
            else if (code != CODE_NONE) start_note(code);
            else step = NS_AWAIT;
            return 1'b0;
        end
        if (c == CH_HASH && step == NS_LETTER)
        begin
            if (!cur_rest) cur_sharp = 1'b1;
            step = NS_SHARPED;
            return 1'b0;
        end
        if (c == CH_FLAT && (step == NS_LETTER || step == NS_SHARPED))
        begin
            // A flat is the sharp of the letter below; A wraps to G one octave down.
            if (!cur_rest)
            begin
                if (cur_letter == 3'(LETTER_A))
                begin
                    cur_letter = 3'(LETTER_G);
                    cur_low = 1'b1;
                end
                else
                    cur_letter = cur_letter - 3'd1;
                cur_sharp = 1'b1;
            end
            step = NS_FLATTED;
            return 1'b0;
        end
        if (c == CH_DOT && step <= NS_OCTAVE)
        begin
            if (int'(cur_dots) < DOT_LIMIT) cur_dots = cur_dots + 2'd1;
            step = (step == NS_OCTAVE) ? NS_OCTAVE : NS_DOTTED;
            return 1'b0;
        end
        if (is_digit(c) && step <= NS_DOTTED)
        begin
            cur_oct = 4'(c - CH_ZERO);
            step = NS_OCTAVE;
            return 1'b0;
        end
        if (c == CH_SPACE)
        begin
            step = NS_SPACED;
            return 1'b0;
        end
        // Anything else ends the note and is used up with it.
        r = open_note();
        step = NS_AWAIT;
        return 1'b1;
    endfunction

    // Feeds one input transaction to the model; returns 1 when a result is due.
    function automatic bit ringtone_step(input logic [7:0] c, input logic fin,
                                         output ringtone_note_t r);
        bit got;
        got = 1'b0;
        r = NO_NOTE;
        case (phase)
            SONG_TITLE:
                if (c == CH_COLON) phase = SONG_DEFAULTS;
            SONG_DEFAULTS:
            begin
                if (c == CH_COLON) phase = SONG_NOTES;
                else if (c == "d" || c == "D")
                begin
                    key = DEF_LEN;
                    def_len = '0;
                end
                else if (c == "o" || c == "O")
                begin
                    key = DEF_OCT;
                    def_oct = '0;
                end
                else if (c == "b" || c == "B")
                begin
                    key = DEF_BPM;
                    bpm = '0;
                end
                else if (is_digit(c))
                begin
                    if (key == DEF_OCT) def_oct = 4'(add_digit({6'd0, def_oct}, c, 15));
                    else if (key == DEF_BPM) bpm = add_digit(bpm, c, 1023);
                    else def_len = add_digit(def_len, c, 1023);
                end
            end
            default:
                got = note_char(c, r);
        endcase
        if (fin)
        begin
            // The last byte always answers: the note it closes or leaves open, or
            // else an end marker. Then the parser starts over.
            if (!got)
            begin
                if (phase == SONG_NOTES && step >= NS_LETTER) r = open_note();
                else r = END_MARK;
            end
            r.song_end = 1'b1;
            got = 1'b1;
            clear_parser();
        end
        return got;
    endfunction

    // ------------------------------------------------------------------
    // Random ringtone text
    // ------------------------------------------------------------------

    function automatic void push_number(input int v);
        string s;
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++) song_chars.push_back(s[i]);
    endfunction

    function automatic void push_dots();
        int n;
        n = ($urandom_range(0, 2) == 0) ? int'($urandom_range(1, 5)) : 0;
        repeat (n) song_chars.push_back(CH_DOT);
    endfunction

    // Mostly the usual note values; now and then anything from zero to far past 1023.
    function automatic int pick_len();
        if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 9999));
        return 1 << $urandom_range(0, 5);
    endfunction

    // Builds one ringtone into song_chars. Most are well formed with random content;
    // some are pure noise and some are cut short, so the last byte lands anywhere.
    function automatic void build_song();
        string note_chars;
        string key_chars;
        logic [7:0] c;
        int first_key;
        int n_notes;
        int cut;
        note_chars = "ABCDEFGabcdefgpP";
        key_chars = "dobDOB";
        song_chars.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 12)) song_chars.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 3))
        begin
            c = 8'($urandom_range(0, 255));
            song_chars.push_back((c == CH_COLON) ? 8'("x") : c);
        end
        song_chars.push_back(CH_COLON);

        // Defaults in a rotated order, each one sometimes left out.
        first_key = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++)
        begin
            int k;
            k = (first_key + i) % 3;
            if ($urandom_range(0, 9) != 0)
            begin
                song_chars.push_back(key_chars[k + 3 * int'($urandom_range(0, 1))]);
                song_chars.push_back("=");
                case (k)
                    0:       push_number(pick_len());
                    1:       push_number(($urandom_range(0, 9) == 0) ?
                                         int'($urandom_range(10, 99)) :
                                         int'($urandom_range(0, 9)));
                    default: push_number(($urandom_range(0, 9) == 0) ?
                                         int'($urandom_range(0, 9999)) :
                                         int'($urandom_range(25, 400)));
                endcase
                song_chars.push_back(($urandom_range(0, 3) == 0) ? CH_SPACE : CH_COMMA);
            end
        end
        song_chars.push_back(CH_COLON);

        n_notes = $urandom_range(1, 8);
        for (int n = 0; n < n_notes; n++)
        begin
            if ($urandom_range(0, 7) == 0) song_chars.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1) != 0) push_number(pick_len());
            song_chars.push_back(note_chars[$urandom_range(0, note_chars.len() - 1)]);
            if ($urandom_range(0, 4) == 0) song_chars.push_back(CH_HASH);
            if ($urandom_range(0, 3) == 0) song_chars.push_back(CH_FLAT);
            push_dots();
            if ($urandom_range(0, 1) != 0)
                song_chars.push_back(($urandom_range(0, 3) == 0) ?
                                     CH_ZERO : 8'(CH_ZERO + $urandom_range(0, 9)));
            push_dots();
            if ($urandom_range(0, 4) == 0) song_chars.push_back(CH_SPACE);
            // The final note is left open about half the time.
            if (n < n_notes - 1 || $urandom_range(0, 1) != 0)
                song_chars.push_back(($urandom_range(0, 5) == 0) ?
                                     8'($urandom_range(0, 255)) : CH_COMMA);
        end

        if ($urandom_range(0, 9) == 0)
        begin
            cut = $urandom_range(1, song_chars.size());
            while (song_chars.size() > cut) void'(song_chars.pop_back());
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offers one character and waits for its transaction. The model runs as soon
    // as the character is put on the port, since it will be accepted unchanged.
    // Valid is only lowered while idling, so it never gets two updates in one step.
    task automatic send_char(input logic [7:0] c, input logic fin, input logic typed,
                             input ringtone_note_t want);
        ringtone_note_t r;
        bit got;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        got = ringtone_step(c, fin, r);
        if (typed) note_q.push_back(want);
        else if (got) note_q.push_back(r);
        in_valid  <= 1'b1;
        text_byte <= c;
        last_byte <= fin;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        text_sent++;
    endtask

    // Holds the input back until every predicted note has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (note_q.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    function automatic void flag_field(input string fname, input logic signed [31:0] want_v,
                                       input logic signed [31:0] got_v);
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, fname, want_v, got_v);
        errors++;
    endfunction

    function automatic void check_note(input ringtone_note_t act);
        ringtone_note_t want;
        if (note_q.size() == 0)
        begin
            $display("%0t ns: unexpected note, expected none, got kind %0d letter %0d ms %0d",
                     $time, act.kind, act.letter, act.ms);
            errors++;
            return;
        end
        want = note_q.pop_front();
        if (act.kind !== want.kind) flag_field("note_kind", want.kind, act.kind);
        if (act.letter !== want.letter) flag_field("note_letter", want.letter, act.letter);
        if (act.sharp !== want.sharp) flag_field("sharp", want.sharp, act.sharp);
        if (act.octave !== want.octave) flag_field("note_octave", want.octave, act.octave);
        if (act.ms !== want.ms) flag_field("duration_ms", want.ms, act.ms);
        if (act.song_end !== want.song_end) flag_field("song_end", want.song_end, act.song_end);
        case (want.kind)
            rtp_pkg::KIND_NOTE: notes_seen++;
            rtp_pkg::KIND_REST: rests_seen++;
            default:            marks_seen++;
        endcase
    endfunction

    // Values are sampled at the edge before any register of the block moves, and
    // out_ready gets exactly one update per edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) check_note(seen_note);
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Watchdog: the run is stuck when neither channel completes a transaction while
    // the quiet counter climbs to QUIET_LIMIT.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("%0t ns: no transaction for %0d cycles, %0d notes outstanding",
                     $time, QUIET_LIMIT, note_q.size());
            $display("[rtttl_ringtone_parser] ERROR");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin
        int dir_sent;
        int song_no;
        clear_parser();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_char(dir_rows[i].ch, dir_rows[i].fin, dir_rows[i].typed, dir_rows[i].want);
        dir_sent = text_sent;
        wait_drained();

        // Random ringtones. A few songs in the middle run with no idling on either
        // side, and every fourth song the input waits for the output to empty.
        song_no = 0;
        while (text_sent - dir_sent < RANDOM_BYTES)
        begin
            build_song();
            steady = (song_no >= 4 && song_no < 7);
            for (int i = 0; i < song_chars.size(); i++)
                send_char(song_chars[i], i == song_chars.size() - 1, 1'b0, NO_NOTE);
            song_no++;
            if (song_no % 4 == 0) wait_drained();
        end
        steady = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d text bytes in %0d directed rows and %0d random songs.",
                 text_sent, DIR_ROWS, song_no);
        $display("Checked %0d pitched notes, %0d rests and %0d end markers.",
                 notes_seen, rests_seen, marks_seen);
        if (errors == 0)
            $display("[rtttl_ringtone_parser] OK");
        else
            $display("[rtttl_ringtone_parser] ERROR");
        $finish;
    end

endmodule
